@@ src/cpac_pkg.sv @@
// ----------------------------------------------------------------------------
// cpac_pkg - shared types and constants for the controller pak access block
// Holds the transaction structs, command codes and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package cpac_pkg;

    // input opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // rumble command codes
    localparam logic [1:0] RUMBLE_NONE  = 2'd0;
    localparam logic [1:0] RUMBLE_START = 2'd1;
    localparam logic [1:0] RUMBLE_STOP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RAW_PAK_PORTS       = 2'd0;
    localparam logic [1:0] CFG_MOTOR_PRESENT_PORTS = 2'd1;
    localparam logic [1:0] CFG_RUMBLE_ADDRESS      = 2'd2;

    localparam int unsigned  CFG_INDEX_W       = 2;
    localparam int unsigned  CFG_DATA_W        = 16;
    localparam logic [15:0]  RUMBLE_ADDR_RESET = 16'hC000;

    // address handling
    localparam logic [15:0] ADDR_MASK = 16'hFFE0;
    localparam logic [15:0] FILL_LO   = 16'h8000;
    localparam logic [15:0] FILL_HI   = 16'h9000;
    localparam logic [7:0]  FILL_SET  = 8'h80;
    localparam logic [7:0]  FILL_CLR  = 8'h00;

    // crc-8
    localparam logic [7:0] CRC_POLY = 8'h85;

    // job queue between front and back
    localparam int unsigned JOBQ_DEPTH = 4;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  port;
        logic [15:0] address;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_crc;
        logic       last;
        logic [1:0] rumble_cmd;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  raw_pak_ports;
        logic [3:0]  motor_present_ports;
        logic [15:0] rumble_address;
    } t_cfg;

    // read job: value is the fill byte; write job: value is the finished crc
    typedef struct packed {
        logic       is_read;
        logic [7:0] value;
        logic [1:0] rumble_cmd;
    } t_job;

    // msb-first crc-8 over one byte, no reflection, no final xor
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ src/cpac_front.sv @@
// ----------------------------------------------------------------------------
// cpac_front - accepts and classifies pak accesses
// Filters ports not in raw mode, tracks the write run crc and posts jobs.
// ----------------------------------------------------------------------------
module cpac_front #(
    parameter int unsigned BLOCK_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  cpac_pkg::t_in_item i_item,
    input  cpac_pkg::t_cfg    i_cfg,
    output logic              o_job_push,
    output cpac_pkg::t_job    o_job
);
    import cpac_pkg::*;

    localparam int unsigned CNT_W = $clog2(BLOCK_BYTES + 1);

    logic [7:0]       r_crc, n_crc;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_first_nz, n_first_nz;
    logic [15:0]      r_wr_addr, n_wr_addr;

    logic [15:0]      addr_m;
    logic             port_raw;
    logic             port_motor;
    logic             run_first;
    logic [7:0]       crc_in;
    logic [7:0]       crc_new;
    logic [15:0]      run_addr;
    logic             run_nz;
    logic [CNT_W-1:0] count_inc;
    logic             run_done;
    logic [7:0]       fill;

    // classification of the incoming transaction
    always_comb begin
        addr_m     = i_item.address & ADDR_MASK;
        port_raw   = i_cfg.raw_pak_ports[i_item.port];
        port_motor = i_cfg.motor_present_ports[i_item.port];
        fill       = (addr_m >= FILL_LO && addr_m < FILL_HI) ? FILL_SET : FILL_CLR;
        run_first  = (r_count == '0);
        crc_in     = run_first ? 8'h00 : r_crc;
        crc_new    = crc8_byte(crc_in, i_item.data_byte);
        run_addr   = run_first ? addr_m : r_wr_addr;
        run_nz     = run_first ? (i_item.data_byte != 8'h00) : r_first_nz;
        count_inc  = r_count + CNT_W'(1);
        run_done   = (count_inc == CNT_W'(BLOCK_BYTES));
    end

    // write run state and job posting
    always_comb begin
        n_crc      = r_crc;
        n_count    = r_count;
        n_first_nz = r_first_nz;
        n_wr_addr  = r_wr_addr;
        o_job_push = 1'b0;
        o_job      = '{is_read: 1'b1, value: fill, rumble_cmd: RUMBLE_NONE};
        if (i_accept && port_raw) begin
            if (i_item.opcode == OP_READ) begin
                o_job_push = 1'b1;
            end else begin
                n_wr_addr = run_addr;
                if (run_done) begin
                    o_job_push       = 1'b1;
                    o_job.is_read    = 1'b0;
                    o_job.value      = crc_new;
                    if (run_addr == i_cfg.rumble_address && port_motor) begin
                        o_job.rumble_cmd = run_nz ? RUMBLE_START : RUMBLE_STOP;
                    end
                    n_crc      = 8'h00;
                    n_count    = '0;
                    n_first_nz = 1'b0;
                end else begin
                    n_crc      = crc_new;
                    n_count    = count_inc;
                    n_first_nz = run_nz;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= 8'h00;
            r_count    <= '0;
            r_first_nz <= 1'b0;
            r_wr_addr  <= 16'h0000;
        end else begin
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_first_nz <= n_first_nz;
            r_wr_addr  <= n_wr_addr;
        end
    end

endmodule

@@ src/cpac_jobq.sv @@
// ----------------------------------------------------------------------------
// cpac_jobq - short job queue between front and back
// Register-based fifo; the oldest job is shown while valid is high.
// ----------------------------------------------------------------------------
module cpac_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cpac_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output cpac_pkg::t_job o_job
);
    import cpac_pkg::*;

    localparam int unsigned PTR_W = $clog2(JOBQ_DEPTH);
    localparam int unsigned CNT_W = $clog2(JOBQ_DEPTH + 1);

    t_job             r_slot [JOBQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(JOBQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ src/cpac_back.sv @@
// ----------------------------------------------------------------------------
// cpac_back - carries out queued jobs and drives the result register
// Expands a read job into its fill bytes and crc; passes write crcs through.
// ----------------------------------------------------------------------------
module cpac_back #(
    parameter int unsigned BLOCK_BYTES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  cpac_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                o_out_valid,
    input  logic                i_out_pop,
    output cpac_pkg::t_out_item o_out
);
    import cpac_pkg::*;

    localparam int unsigned CNT_W = $clog2(BLOCK_BYTES + 1);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_fill, n_fill;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic             advance;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // result register moves when empty or being taken
    always_comb begin
        advance     = !r_out_valid || i_out_pop;
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_fill      = r_fill;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_job_pop   = 1'b0;
        if (advance) begin
            n_out_valid = 1'b0;
            if (r_busy) begin
                n_out_valid = 1'b1;
                if (r_cnt < CNT_W'(BLOCK_BYTES)) begin
                    // next fill byte of the read run
                    n_out = '{out_byte: r_fill, is_crc: 1'b0, last: 1'b0,
                              rumble_cmd: RUMBLE_NONE};
                    n_crc = crc8_byte(r_crc, r_fill);
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    // closing crc of the read run
                    n_out  = '{out_byte: r_crc, is_crc: 1'b1, last: 1'b1,
                               rumble_cmd: RUMBLE_NONE};
                    n_busy = 1'b0;
                end
            end else if (i_job_valid) begin
                o_job_pop   = 1'b1;
                n_out_valid = 1'b1;
                if (i_job.is_read) begin
                    n_out  = '{out_byte: i_job.value, is_crc: 1'b0, last: 1'b0,
                               rumble_cmd: RUMBLE_NONE};
                    n_crc  = crc8_byte(8'h00, i_job.value);
                    n_cnt  = CNT_W'(1);
                    n_fill = i_job.value;
                    n_busy = 1'b1;
                end else begin
                    n_out = '{out_byte: i_job.value, is_crc: 1'b1, last: 1'b1,
                              rumble_cmd: i_job.rumble_cmd};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_crc  <= n_crc;
        r_fill <= n_fill;
        r_out  <= n_out;
    end

endmodule

@@ src/controller_pak_access_crc.sv @@
// ----------------------------------------------------------------------------
// controller_pak_access_crc - raw controller pak responder with crc-8
// Front classifies accesses, a four-entry job queue decouples the back end.
// ----------------------------------------------------------------------------
// A write byte is taken every cycle while full is low; byte BLOCK_BYTES of a run
// queues one crc result. A read request queues a job that the back end turns
// into BLOCK_BYTES fill bytes and their crc, one result per cycle while results
// are taken, so a read holds the back end for all of them and a write for one
// result; the queue between front and back absorbs a burst of up to four jobs
// before full rises. Results leave through one register: empty low shows the
// oldest. Accesses to ports not in raw mode are swallowed without results.
module controller_pak_access_crc #(
    parameter int unsigned BLOCK_BYTES = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  cpac_pkg::t_in_item                   i_item,
    output logic                                 empty,
    input  logic                                 pop,
    output cpac_pkg::t_out_item                  o_result,
    input  logic                                 i_cfg_we,
    input  logic [cpac_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [cpac_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cpac_pkg::*;

    t_cfg  r_cfg;
    logic  accept;
    logic  job_push;
    t_job  job_in;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_job  job_out;
    logic  out_valid;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = !out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_pak_ports       <= 4'h0;
            r_cfg.motor_present_ports <= 4'h0;
            r_cfg.rumble_address      <= RUMBLE_ADDR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RAW_PAK_PORTS:       r_cfg.raw_pak_ports       <= i_cfg_data[3:0];
                CFG_MOTOR_PRESENT_PORTS: r_cfg.motor_present_ports <= i_cfg_data[3:0];
                CFG_RUMBLE_ADDRESS:      r_cfg.rumble_address      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cpac_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    cpac_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (job_out)
    );

    cpac_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_job_pop   (q_pop),
        .o_out_valid (out_valid),
        .i_out_pop   (pop),
        .o_out       (o_result)
    );

    // a job is only posted by an accepted transaction
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> accept)
        else $error("job posted without an accepted transaction");

    // a posted job always finds room in the queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_push && q_full))
        else $error("job queue overflow");

    // fill bytes never carry crc, last or rumble marks
    a_fill_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.is_crc) |->
            (!o_result.last && o_result.rumble_cmd == RUMBLE_NONE))
        else $error("fill byte carries crc markings");

    // a job popped from the queue lands in the result register next cycle
    a_pop_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !empty)
        else $error("popped job produced no result");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - self-checking bench for controller_pak_access_crc
// Feeds read requests and write-byte runs through the push/full side and
// checks every popped result against an in-bench model of the pak responder
// (fill runs, running crc-8, rumble commands) across several register settings.
// ----------------------------------------------------------------------------
module testbench;

    import cpac_pkg::*;

    localparam int RUN_BYTES = 32;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    t_in_item    i_item      = '0;
    logic        pop         = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        full;
    logic        empty;
    t_out_item   o_result;

    // transactions waiting to be offered, results waiting to be seen
    t_in_item  pending_items[$];
    t_out_item expected_results[$];

    // bench copy of the registers
    logic [3:0]  cfg_raw         = 4'h0;
    logic [3:0]  cfg_motor       = 4'h0;
    logic [15:0] cfg_rumble_addr = RUMBLE_ADDR_RESET;

    // bench copy of the write run state
    logic [7:0]  run_crc      = 8'h00;
    int          run_bytes    = 0;
    logic        run_first_nz = 1'b0;
    logic [15:0] run_addr     = 16'h0000;

    // stimulus control
    int          sender_idle_pct = 0;
    int          recv_idle_pct   = 0;
    logic        hold_results    = 1'b0;
    int          gen_bytes       = 0;
    logic [1:0]  gen_port        = 2'd0;
    int          mismatch_count  = 0;

    controller_pak_access_crc #(
        .BLOCK_BYTES(RUN_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // msb-first crc-8 over one byte
    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] s;
        s = acc ^ b;
        repeat (8) s = s[7] ? ((s << 1) ^ CRC_POLY) : (s << 1);
        return s;
    endfunction

    function automatic void queue_result(input logic [7:0] value, input logic is_crc,
                                         input logic last, input logic [1:0] cmd);
        t_out_item r;
        r.out_byte   = value;
        r.is_crc     = is_crc;
        r.last       = last;
        r.rumble_cmd = cmd;
        expected_results.push_back(r);
    endfunction

    // expected results of one accepted transaction
    function automatic void predict_access(input t_in_item it);
        logic [15:0] blk;
        logic [7:0]  fill;
        logic [7:0]  sum;
        logic [1:0]  cmd;
        if (!cfg_raw[it.port]) return;
        blk = it.address & ADDR_MASK;
        if (it.opcode == OP_READ) begin
            fill = (blk >= FILL_LO && blk < FILL_HI) ? FILL_SET : FILL_CLR;
            sum  = 8'h00;
            for (int k = 0; k < RUN_BYTES; k++) begin
                queue_result(fill, 1'b0, 1'b0, RUMBLE_NONE);
                sum = crc8_next(sum, fill);
            end
            queue_result(sum, 1'b1, 1'b1, RUMBLE_NONE);
            return;
        end
        // first byte of a run latches address and start/stop choice
        if (run_bytes == 0) begin
            run_addr     = blk;
            run_first_nz = (it.data_byte != 8'h00);
            run_crc      = 8'h00;
        end
        run_crc   = crc8_next(run_crc, it.data_byte);
        run_bytes = run_bytes + 1;
        if (run_bytes == RUN_BYTES) begin
            cmd = RUMBLE_NONE;
            if (run_addr == cfg_rumble_addr && cfg_motor[it.port])
                cmd = run_first_nz ? RUMBLE_START : RUMBLE_STOP;
            queue_result(run_crc, 1'b1, 1'b1, cmd);
            run_bytes    = 0;
            run_crc      = 8'h00;
            run_first_nz = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("error at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending", got, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
        if (got.is_crc !== want.is_crc)
            report_mismatch("is_crc", got.is_crc, want.is_crc);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
        if (got.rumble_cmd !== want.rumble_cmd)
            report_mismatch("rumble_cmd", got.rumble_cmd, want.rumble_cmd);
    endtask

    // driver: offer the oldest pending transaction, hold it while full
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_access(i_item);
                pending_items.delete(0);
            end
            if (push && full) begin
                push <= 1'b1;
            end else if (pending_items.size() != 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                push   <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: check each popped result, pop at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_result(o_result);
            pop <= !hold_results && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_RAW_PAK_PORTS:       cfg_raw = value[3:0];
            CFG_MOTOR_PRESENT_PORTS: cfg_motor = value[3:0];
            CFG_RUMBLE_ADDRESS:      cfg_rumble_addr = value;
            default: ;
        endcase
    endtask

    // wait for every transaction and result, then let the back end settle
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || push || expected_results.size() != 0);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic queue_access(input logic op, input logic [1:0] port,
                                input logic [15:0] addr, input logic [7:0] data);
        t_in_item it;
        it.opcode    = op;
        it.port      = port;
        it.address   = addr;
        it.data_byte = data;
        pending_items.push_back(it);
    endtask

    // random port among those in raw mode, any port when none is
    function automatic logic [1:0] raw_port();
        logic [1:0] p;
        p = 2'($urandom_range(0, 3));
        repeat (4) begin
            if (cfg_raw[p]) return p;
            p = p + 2'd1;
        end
        return p;
    endfunction

    // mostly well-formed write runs, with reads and stray transactions mixed in
    task automatic queue_random(input int count);
        t_in_item it;
        int       pick;
        for (int k = 0; k < count; k++) begin
            pick         = $urandom_range(0, 99);
            it.data_byte = 8'($urandom_range(0, 255));
            it.address   = 16'($urandom_range(0, 65535));
            if (pick < 12) begin
                it.opcode = OP_READ;
                it.port   = raw_port();
                if ($urandom_range(0, 1)) it.address = {4'h8, 12'($urandom_range(0, 4095))};
            end else if (pick < 20) begin
                it.opcode = 1'($urandom_range(0, 1));
                it.port   = 2'($urandom_range(0, 3));
            end else begin
                it.opcode = OP_WRITE;
                if (gen_bytes == 0) begin
                    gen_port = raw_port();
                    if ($urandom_range(0, 1))
                        it.address = cfg_rumble_addr | 16'($urandom_range(0, 31));
                    if ($urandom_range(0, 2) == 0) it.data_byte = 8'h00;
                end else if (gen_bytes == RUN_BYTES - 1 && $urandom_range(0, 3) == 0) begin
                    // final byte from a freshly picked port decides the motor check
                    gen_port = raw_port();
                end
                it.port = gen_port;
            end
            if (it.opcode == OP_WRITE && cfg_raw[it.port])
                gen_bytes = (gen_bytes + 1) % RUN_BYTES;
            pending_items.push_back(it);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input logic [3:0] raw,
                             input logic [3:0] motor, input logic [15:0] rumble,
                             input int count);
        write_register(CFG_RAW_PAK_PORTS, {12'h000, raw});
        write_register(CFG_MOTOR_PRESENT_PORTS, {12'h000, motor});
        write_register(CFG_RUMBLE_ADDRESS, rumble);
        @(negedge i_clk);
        sender_idle_pct = send_pct;
        recv_idle_pct   = recv_pct;
        gen_bytes       = run_bytes;
        gen_port        = raw_port();
        queue_random(count);
        wait_quiet();
    endtask

    initial begin
        sender_idle_pct = 29;
        recv_idle_pct   = 58;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // raw mode is off after reset, so these transactions are swallowed
        @(negedge i_clk);
        queue_access(OP_READ, 2'd0, 16'h8000, 8'h00);
        queue_access(OP_WRITE, 2'd3, 16'hC000, 8'h01);
        wait_quiet();

        // fill range edges on every port
        write_register(CFG_RAW_PAK_PORTS, 16'h000F);
        write_register(CFG_MOTOR_PRESENT_PORTS, 16'h000F);
        @(negedge i_clk);
        queue_access(OP_READ, 2'd0, 16'h0000, 8'h00);
        queue_access(OP_READ, 2'd1, 16'h7FFF, 8'hFF);
        queue_access(OP_READ, 2'd2, 16'h8000, 8'h00);
        queue_access(OP_READ, 2'd3, 16'h8FFF, 8'h00);
        queue_access(OP_READ, 2'd0, 16'h9000, 8'h00);
        queue_access(OP_READ, 2'd1, 16'hFFFF, 8'h00);
        // start of a run on the rumble block, a read in the middle of it,
        // later bytes with unrelated addresses
        queue_access(OP_WRITE, 2'd2, 16'hC01F, 8'hFF);
        queue_access(OP_WRITE, 2'd2, 16'h1234, 8'h00);
        queue_access(OP_READ, 2'd3, 16'h8123, 8'h00);
        queue_access(OP_WRITE, 2'd2, 16'hFFFF, 8'hA5);
        wait_quiet();

        run_phase(29, 58, 4'hF, 4'h5, 16'hC000, 40);

        // receiver holds off while reads keep arriving, so the block fills up
        @(negedge i_clk);
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        hold_results    = 1'b1;
        for (int k = 0; k < 10; k++)
            queue_access(OP_READ, raw_port(), 16'($urandom_range(0, 65535)), 8'h00);
        repeat (400) @(negedge i_clk);
        hold_results = 1'b0;
        wait_quiet();

        // rumble address with low bits set never matches
        run_phase(58, 29, 4'h6, 4'hF, 16'hC01F, 30);
        run_phase(58, 29, 4'hF, 4'hA, 16'h0000, 15);
        run_phase(0, 0, 4'hF, 4'hF, 16'($urandom_range(0, 65535)) & ADDR_MASK, 30);
        run_phase(0, 0, 4'h9, 4'h0, 16'hFFFF, 15);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
